@@ rtl/core/srp_pkg.sv @@
// ----------------------------------------------------------------------------
// srp_pkg
// Types and constants shared by the SOCKS5 reply parser modules.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam logic [7:0] SocksVersion = 8'h05;
  localparam logic [7:0] AtypIpv4     = 8'h01;
  localparam logic [7:0] AtypDomain   = 8'h03;
  localparam logic [7:0] AtypIpv6     = 8'h04;
  localparam logic [7:0] LenIpv4      = 8'd4;
  localparam logic [7:0] LenIpv6      = 8'd16;
  localparam logic [7:0] LenPort      = 8'd2;

  typedef enum logic [3:0] {
    PhVersion  = 4'd0,
    PhReply    = 4'd1,
    PhReserved = 4'd2,
    PhAddrType = 4'd3,
    PhDomLen   = 4'd4,
    PhAddress  = 4'd5,
    PhPort     = 4'd6,
    PhDone     = 4'd7,
    PhBadVer   = 4'd8,
    PhBadType  = 4'd9
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  reply_code;
    logic [7:0]  address_type;
    logic        address_byte_valid;
    logic [7:0]  address_byte;
    logic [7:0]  address_index;
    logic [15:0] port_number;
    logic        finished;
    logic        failed;
  } out_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  reply;
    logic [7:0]  atype;
    logic [7:0]  cnt;
    logic [7:0]  target;
    logic [15:0] port;
  } state_t;

  localparam state_t StateReset = '{
    phase:  PhVersion,
    reply:  8'd0,
    atype:  8'd0,
    cnt:    8'd0,
    target: 8'd0,
    port:   16'd0
  };

endpackage

@@ rtl/core/srp_in_reg.sv @@
// ----------------------------------------------------------------------------
// srp_in_reg
// Input register: holds one accepted byte until the parse step takes it.
// ----------------------------------------------------------------------------
module srp_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  srp_pkg::in_t  in_data_i,
  input  logic          take_i,
  output logic          valid_o,
  output srp_pkg::in_t  data_o
);

  logic         valid_q, valid_d;
  srp_pkg::in_t data_q;
  logic         accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/core/srp_step.sv @@
// ----------------------------------------------------------------------------
// srp_step
// One parse step: next parser state and the result for one byte.
// ----------------------------------------------------------------------------
module srp_step (
  input  srp_pkg::state_t state_i,
  input  srp_pkg::in_t    item_i,
  output srp_pkg::state_t state_o,
  output srp_pkg::out_t   result_o
);

  srp_pkg::state_t cur;
  srp_pkg::state_t nxt;
  logic [7:0]      b;
  logic [7:0]      cnt_inc;
  logic            addr_valid;
  logic            fin;
  logic            err;

  assign b       = item_i.data_byte;
  assign cur     = item_i.restart ? srp_pkg::StateReset : state_i;
  assign cnt_inc = cur.cnt + 8'd1;

  always_comb begin
    nxt        = cur;
    addr_valid = 1'b0;
    case (cur.phase)
      srp_pkg::PhVersion: begin
        nxt.phase = (b == srp_pkg::SocksVersion) ? srp_pkg::PhReply : srp_pkg::PhBadVer;
      end
      srp_pkg::PhReply: begin
        nxt.reply = b;
        nxt.phase = srp_pkg::PhReserved;
      end
      srp_pkg::PhReserved: begin
        nxt.phase = srp_pkg::PhAddrType;
      end
      srp_pkg::PhAddrType: begin
        nxt.atype = b;
        if (b == srp_pkg::AtypIpv4) begin
          nxt.cnt    = 8'd0;
          nxt.target = srp_pkg::LenIpv4;
          nxt.phase  = srp_pkg::PhAddress;
        end else if (b == srp_pkg::AtypIpv6) begin
          nxt.cnt    = 8'd0;
          nxt.target = srp_pkg::LenIpv6;
          nxt.phase  = srp_pkg::PhAddress;
        end else if (b == srp_pkg::AtypDomain) begin
          nxt.phase = srp_pkg::PhDomLen;
        end else begin
          nxt.phase = srp_pkg::PhBadType;
        end
      end
      srp_pkg::PhDomLen: begin
        nxt.cnt = 8'd0;
        if (b == 8'd0) begin
          nxt.target = srp_pkg::LenPort;
          nxt.port   = 16'd0;
          nxt.phase  = srp_pkg::PhPort;
        end else begin
          nxt.target = b;
          nxt.phase  = srp_pkg::PhAddress;
        end
      end
      srp_pkg::PhAddress: begin
        addr_valid = 1'b1;
        if (cnt_inc >= cur.target) begin
          nxt.cnt    = 8'd0;
          nxt.target = srp_pkg::LenPort;
          nxt.port   = 16'd0;
          nxt.phase  = srp_pkg::PhPort;
        end else begin
          nxt.cnt = cnt_inc;
        end
      end
      srp_pkg::PhPort: begin
        nxt.port = {cur.port[7:0], b};
        nxt.cnt  = cnt_inc;
        if (cnt_inc >= cur.target) begin
          nxt.phase = srp_pkg::PhDone;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign err = (nxt.phase == srp_pkg::PhBadVer) || (nxt.phase == srp_pkg::PhBadType);
  assign fin = err || (nxt.phase == srp_pkg::PhDone);

  assign state_o = nxt;

  always_comb begin
    result_o.phase              = nxt.phase;
    result_o.reply_code         = nxt.reply;
    result_o.address_type       = nxt.atype;
    result_o.address_byte_valid = addr_valid;
    result_o.address_byte       = addr_valid ? b : 8'd0;
    result_o.address_index      = addr_valid ? cur.cnt : 8'd0;
    result_o.port_number        = nxt.port;
    result_o.finished           = fin;
    result_o.failed             = err;
  end

endmodule

@@ rtl/core/srp_out_reg.sv @@
// ----------------------------------------------------------------------------
// srp_out_reg
// Result register: holds one result until the sink takes the transfer.
// ----------------------------------------------------------------------------
module srp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  srp_pkg::out_t result_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output srp_pkg::out_t out_data_o
);

  logic          valid_q, valid_d;
  srp_pkg::out_t data_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/core/socks5_reply_parser_core.sv @@
// ----------------------------------------------------------------------------
// socks5_reply_parser_core
// SOCKS5 server reply parser, one byte per transfer, one result per byte.
// ----------------------------------------------------------------------------
// Takes one reply byte per cycle and returns one result per byte while the
// output is not stalled: the byte is held in the input register, then the
// combinational parse step updates the parser state and loads the result
// register. The parser state register takes the step's next state, so a
// full byte stream runs at one byte per clock unless the output stalls.
// A set restart bit clears the parser before its own byte is parsed as version.
module socks5_reply_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  srp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output srp_pkg::out_t out_data_o
);

  logic            item_valid;
  srp_pkg::in_t    item;
  logic            out_ready;
  logic            fire;
  srp_pkg::state_t state_q, state_d;
  srp_pkg::out_t   result;

  srp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (out_ready),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  srp_step u_step (
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (result)
  );

  assign fire = item_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srp_pkg::StateReset;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  srp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("parser state changed without a step");

  a_addr_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.address_byte_valid |->
      (out_data_o.phase == srp_pkg::PhAddress) || (out_data_o.phase == srp_pkg::PhPort))
    else $error("address byte reported outside address or port phase");

  a_fail_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.failed |-> out_data_o.finished)
    else $error("failed result not marked finished");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid |-> !in_stall_o)
    else $error("input stalled with empty input register");

endmodule

@@ tb/socks5_reply_parser_core_checker.sv @@
// ----------------------------------------------------------------------------
// socks5_reply_parser_core_checker
// Watches both channels of the SOCKS5 reply parser, predicts each result from
// the accepted input bytes and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module socks5_reply_parser_core_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  srp_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  srp_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  srp_pkg::phase_e cur_phase;
  logic [7:0]      reply_q;
  logic [7:0]      atype_q;
  logic [7:0]      byte_count;
  logic [7:0]      byte_goal;
  logic [15:0]     port_q;

  srp_pkg::out_t   parse_results[$];
  srp_pkg::out_t   predicted;
  srp_pkg::out_t   oldest;
  int              fails;
  int              checked;
  int              pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign checked_o    = checked;

  task automatic clear_parser();
    cur_phase  = srp_pkg::PhVersion;
    reply_q    = '0;
    atype_q    = '0;
    byte_count = '0;
    byte_goal  = '0;
    port_q     = '0;
  endtask

  task automatic start_port();
    byte_count = '0;
    byte_goal  = srp_pkg::LenPort;
    port_q     = '0;
    cur_phase  = srp_pkg::PhPort;
  endtask

  task automatic parse_byte(input srp_pkg::in_t item, output srp_pkg::out_t res);
    logic [7:0] b;
    b   = item.data_byte;
    res = '0;
    if (item.restart) clear_parser();
    case (cur_phase)
      srp_pkg::PhVersion: begin
        cur_phase = (b == srp_pkg::SocksVersion) ? srp_pkg::PhReply : srp_pkg::PhBadVer;
      end
      srp_pkg::PhReply: begin
        reply_q   = b;
        cur_phase = srp_pkg::PhReserved;
      end
      srp_pkg::PhReserved: cur_phase = srp_pkg::PhAddrType;
      srp_pkg::PhAddrType: begin
        atype_q = b;
        if (b == srp_pkg::AtypIpv4) begin
          byte_count = '0;
          byte_goal  = srp_pkg::LenIpv4;
          cur_phase  = srp_pkg::PhAddress;
        end else if (b == srp_pkg::AtypIpv6) begin
          byte_count = '0;
          byte_goal  = srp_pkg::LenIpv6;
          cur_phase  = srp_pkg::PhAddress;
        end else if (b == srp_pkg::AtypDomain) begin
          cur_phase = srp_pkg::PhDomLen;
        end else begin
          cur_phase = srp_pkg::PhBadType;
        end
      end
      srp_pkg::PhDomLen: begin
        if (b == 8'd0) begin
          start_port();
        end else begin
          byte_count = '0;
          byte_goal  = b;
          cur_phase  = srp_pkg::PhAddress;
        end
      end
      srp_pkg::PhAddress: begin
        res.address_byte_valid = 1'b1;
        res.address_byte       = b;
        res.address_index      = byte_count;
        byte_count             = byte_count + 8'd1;
        if (byte_count >= byte_goal) start_port();
      end
      srp_pkg::PhPort: begin
        port_q     = {port_q[7:0], b};
        byte_count = byte_count + 8'd1;
        if (byte_count >= byte_goal) cur_phase = srp_pkg::PhDone;
      end
      default: ;
    endcase
    res.phase        = cur_phase;
    res.reply_code   = reply_q;
    res.address_type = atype_q;
    res.port_number  = port_q;
    res.finished     = cur_phase inside {srp_pkg::PhDone, srp_pkg::PhBadVer,
                                         srp_pkg::PhBadType};
    res.failed       = cur_phase inside {srp_pkg::PhBadVer, srp_pkg::PhBadType};
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      parse_results.delete();
      fails   = 0;
      checked = 0;
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (parse_results.size() == 0) begin
          $error("result transfer with no byte outstanding: %h", out_data_i);
          fails++;
        end else begin
          oldest = parse_results.pop_front();
          check_field("phase", 16'(oldest.phase), 16'(out_data_i.phase));
          check_field("reply_code", 16'(oldest.reply_code), 16'(out_data_i.reply_code));
          check_field("address_type", 16'(oldest.address_type),
                      16'(out_data_i.address_type));
          check_field("address_byte_valid", 16'(oldest.address_byte_valid),
                      16'(out_data_i.address_byte_valid));
          check_field("address_byte", 16'(oldest.address_byte),
                      16'(out_data_i.address_byte));
          check_field("address_index", 16'(oldest.address_index),
                      16'(out_data_i.address_index));
          check_field("port_number", oldest.port_number, out_data_i.port_number);
          check_field("finished", 16'(oldest.finished), 16'(out_data_i.finished));
          check_field("failed", 16'(oldest.failed), 16'(out_data_i.failed));
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(in_data_i, predicted);
        parse_results.push_back(predicted);
      end
      pending = parse_results.size();
    end
  end

endmodule

@@ tb/socks5_reply_parser_core_tb.sv @@
// ----------------------------------------------------------------------------
// socks5_reply_parser_core_tb
// Drives SOCKS5 reply byte streams into the parser: a directed set of
// replies, then random well-formed, truncated and noisy replies under three
// idle profiles. The checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module socks5_reply_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  srp_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  srp_pkg::out_t out_data_o;

  int fail_count;
  int pending;
  int checked;

  int unsigned sender_idle_pct = 7;
  int unsigned recv_idle_pct   = 78;
  int          sent_bytes      = 0;
  int          total_bytes     = 0;

  localparam int NumBytes = 1400;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  socks5_reply_parser_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  socks5_reply_parser_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic rs, input bit counted);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, restart: rs};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    total_bytes++;
    if (counted) sent_bytes++;
    if (sent_bytes >= 2 * NumBytes / 3) begin
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
    end else if (sent_bytes >= NumBytes / 3) begin
      sender_idle_pct = 78;
      recv_idle_pct   = 7;
    end
  endtask

  // One reply with random content; sometimes cut short or followed by junk.
  task automatic send_reply();
    logic [7:0]  reply_bytes[$];
    logic [7:0]  atyp;
    logic [7:0]  dlen;
    int unsigned r;
    int unsigned n;
    int unsigned len;
    reply_bytes.delete();
    reply_bytes.push_back(($urandom_range(99) < 90) ? srp_pkg::SocksVersion : 8'($urandom));
    reply_bytes.push_back(8'($urandom));
    reply_bytes.push_back(8'($urandom));
    r = $urandom_range(99);
    if (r < 30) atyp = srp_pkg::AtypIpv4;
    else if (r < 55) atyp = srp_pkg::AtypIpv6;
    else if (r < 85) atyp = srp_pkg::AtypDomain;
    else atyp = 8'($urandom);
    reply_bytes.push_back(atyp);
    len = 0;
    if (atyp == srp_pkg::AtypIpv4) begin
      len = 32'(srp_pkg::LenIpv4);
    end else if (atyp == srp_pkg::AtypIpv6) begin
      len = 32'(srp_pkg::LenIpv6);
    end else if (atyp == srp_pkg::AtypDomain) begin
      r = $urandom_range(99);
      if (r < 2) dlen = 8'd255;
      else if (r < 8) dlen = 8'($urandom_range(9, 64));
      else dlen = 8'($urandom_range(0, 8));
      reply_bytes.push_back(dlen);
      len = 32'(dlen);
    end
    if (atyp inside {srp_pkg::AtypIpv4, srp_pkg::AtypIpv6, srp_pkg::AtypDomain}) begin
      for (int i = 0; i < int'(len) + 2; i++) reply_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(99) < 10) begin
      n = $urandom_range(reply_bytes.size() - 1, 1);
      while (reply_bytes.size() > n) void'(reply_bytes.pop_back());
    end
    for (int i = 0; i < reply_bytes.size(); i++) begin
      if (i == 0) send_byte(reply_bytes[i], $urandom_range(99) < 90, 1'b1);
      else send_byte(reply_bytes[i], $urandom_range(99) < 1, 1'b1);
    end
    if ($urandom_range(99) < 20) begin
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  initial begin
    int unsigned n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bad version, then a byte ignored in the error state
    send_byte(8'h04, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    // IPv4 with extreme bytes, then a byte ignored in done
    send_byte(srp_pkg::SocksVersion, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(srp_pkg::AtypIpv4, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b1);
    // zero-length domain goes straight to the port
    send_byte(srp_pkg::SocksVersion, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(srp_pkg::AtypDomain, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    // unsupported address type
    send_byte(srp_pkg::SocksVersion, 1'b1, 1'b1);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h02, 1'b0, 1'b1);

    while (sent_bytes < NumBytes) begin
      if ($urandom_range(99) < 10) begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'($urandom), 1'b1);
      end else begin
        send_reply();
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    if (pending != 0) $error("%0d results never arrived", pending);
    $display("Sent %0d bytes: IPv4, IPv6 and domain replies, bad versions and types,",
             total_bytes);
    $display("restarts, truncated replies and noise; %0d results checked", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/srp_pkg.sv
rtl/core/srp_in_reg.sv
rtl/core/srp_step.sv
rtl/core/srp_out_reg.sv
rtl/core/socks5_reply_parser_core.sv
tb/socks5_reply_parser_core_checker.sv
tb/socks5_reply_parser_core_tb.sv
